@@ hw/rtl/pia_pkg.sv @@
// Shared types, codes and the base penalty table of the PCI IRQ allocator.
`timescale 1ns / 1ps

package pia_pkg;

    localparam int NUM_IRQS  = 16;
    localparam int IRQ_IDX_W = 4;
    localparam int BASE_W    = 20;

    localparam logic [2:0] SRC_NONE  = 3'd0;
    localparam logic [2:0] SRC_BIOS  = 3'd1;
    localparam logic [2:0] SRC_HARD  = 3'd2;
    localparam logic [2:0] SRC_FOUND = 3'd3;
    localparam logic [2:0] SRC_NEW   = 3'd4;

    localparam logic [1:0] CFG_TABLE_PRESENT    = 2'd0;
    localparam logic [1:0] CFG_ROUTER_PRESENT   = 2'd1;
    localparam logic [1:0] CFG_ALLOWED_IRQ_MASK = 2'd2;
    localparam logic [1:0] CFG_EXCLUSIVE_IRQS   = 2'd3;

    localparam logic [15:0]       ALLOWED_MASK_RESET = 16'hfff8;
    localparam logic [BASE_W-1:0] EXCL_PENALTY       = 20'd100;
    localparam logic [2:0]        PIN_MAX            = 3'd4;
    localparam logic [3:0]        HARD_NIBBLE        = 4'hf;

    typedef struct packed {
        logic [2:0]  interrupt_pin;
        logic        entry_found;
        logic [7:0]  link_value;
        logic [15:0] pin_bitmap;
        logic [3:0]  current_line;
        logic [3:0]  router_irq;
        logic        assign_allowed;
        logic        is_display;
    } in_t;

    typedef struct packed {
        logic [3:0] granted_irq;
        logic [2:0] source;
        logic       program_router;
    } out_t;

    typedef struct packed {
        logic        table_present;
        logic        router_present;
        logic [15:0] allowed_irq_mask;
        logic [15:0] exclusive_irqs;
    } cfg_t;

    function automatic logic [BASE_W-1:0] base_penalty(input logic [IRQ_IDX_W-1:0] irq);
        logic [BASE_W-1:0] p;
        case (irq) inside
            4'd0, 4'd1, 4'd2:               p = 20'd1000000;
            4'd3, 4'd4, 4'd6, 4'd7, 4'd12:  p = 20'd1000;
            4'd13, 4'd14, 4'd15:            p = 20'd100000;
            default:                        p = '0;
        endcase
        return p;
    endfunction

endpackage

@@ hw/rtl/pia_usage_bank.sv @@
// Per-IRQ usage counters and the effective penalty of every IRQ.
`timescale 1ns / 1ps

module pia_usage_bank #(
    parameter int COUNT_WIDTH = 16,
    parameter int PEN_W       = 21
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [15:0]                        exclusive_irqs,
    input  logic                               inc_en,
    input  logic [pia_pkg::IRQ_IDX_W-1:0]      inc_idx,
    output logic [PEN_W-1:0]                   penalty [pia_pkg::NUM_IRQS]
);
    import pia_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0] count_reg  [NUM_IRQS];
    logic [COUNT_WIDTH-1:0] count_next [NUM_IRQS];
    logic                   excl_any;

    assign excl_any = (exclusive_irqs != '0);

    always_comb
    begin
        for (int i = 0; i < NUM_IRQS; i++)
        begin
            count_next[i] = count_reg[i];
            if (inc_en && inc_idx == IRQ_IDX_W'(i) && count_reg[i] != COUNT_MAX)
            begin
                count_next[i] = count_reg[i] + 1'b1;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_IRQS; i++)
        begin
            // non-exclusive IRQs carry an extra penalty once any IRQ is exclusive
            penalty[i] = PEN_W'(base_penalty(IRQ_IDX_W'(i)))
                       + ((excl_any && !exclusive_irqs[i]) ? PEN_W'(EXCL_PENALTY) : '0)
                       + PEN_W'(count_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_IRQS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_IRQS; i++)
            begin
                count_reg[i] <= count_next[i];
            end
        end
    end

endmodule

@@ hw/rtl/pia_argmin.sv @@
// Four-level compare tree: lowest penalty among the allowed IRQs and IRQ 0, lower index on a tie.
`timescale 1ns / 1ps

module pia_argmin #(
    parameter int PEN_W = 21
) (
    input  logic [PEN_W-1:0]              penalty [pia_pkg::NUM_IRQS],
    input  logic [15:0]                   mask,
    output logic [pia_pkg::IRQ_IDX_W-1:0] pick
);
    import pia_pkg::*;

    logic [PEN_W-1:0]     v1 [8];
    logic [IRQ_IDX_W-1:0] i1 [8];
    logic                 k1 [8];
    logic [PEN_W-1:0]     v2 [4];
    logic [IRQ_IDX_W-1:0] i2 [4];
    logic                 k2 [4];
    logic [PEN_W-1:0]     v3 [2];
    logic [IRQ_IDX_W-1:0] i3 [2];
    logic                 k3 [2];
    logic [15:0]          cand;

    // IRQ 0 is always a candidate of the compare tree
    assign cand = mask | 16'h0001;

    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            if (cand[2*j] && (!cand[2*j+1] || penalty[2*j] <= penalty[2*j+1]))
            begin
                v1[j] = penalty[2*j];
                i1[j] = IRQ_IDX_W'(2*j);
            end
            else
            begin
                v1[j] = penalty[2*j+1];
                i1[j] = IRQ_IDX_W'(2*j+1);
            end
            k1[j] = cand[2*j] | cand[2*j+1];
        end
        for (int j = 0; j < 4; j++)
        begin
            if (k1[2*j] && (!k1[2*j+1] || v1[2*j] <= v1[2*j+1]))
            begin
                v2[j] = v1[2*j];
                i2[j] = i1[2*j];
            end
            else
            begin
                v2[j] = v1[2*j+1];
                i2[j] = i1[2*j+1];
            end
            k2[j] = k1[2*j] | k1[2*j+1];
        end
        for (int j = 0; j < 2; j++)
        begin
            if (k2[2*j] && (!k2[2*j+1] || v2[2*j] <= v2[2*j+1]))
            begin
                v3[j] = v2[2*j];
                i3[j] = i2[2*j];
            end
            else
            begin
                v3[j] = v2[2*j+1];
                i3[j] = i2[2*j+1];
            end
            k3[j] = k2[2*j] | k2[2*j+1];
        end
        if (k3[0] && (!k3[1] || v3[0] <= v3[1]))
        begin
            pick = i3[0];
        end
        else
        begin
            pick = i3[1];
        end
    end

endmodule

@@ hw/rtl/pia_route.sv @@
// Source priority decode: BIOS, hardcoded link, router lookup, new assignment.
`timescale 1ns / 1ps

module pia_route (
    input  pia_pkg::cfg_t                 cfg,
    input  pia_pkg::in_t                  req,
    input  logic [pia_pkg::IRQ_IDX_W-1:0] pick,
    output logic [15:0]                   pick_mask,
    output pia_pkg::out_t                 result
);
    import pia_pkg::*;

    logic       refuse;
    logic [3:0] irq;
    logic [2:0] src;

    assign pick_mask = req.pin_bitmap & cfg.allowed_irq_mask;

    assign refuse = !cfg.table_present || req.interrupt_pin == '0
                 || req.interrupt_pin > PIN_MAX || !req.entry_found
                 || req.link_value == '0;

    always_comb
    begin
        irq = '0;
        src = SRC_NONE;
        if (!refuse)
        begin
            if (req.current_line != '0)
            begin
                irq = req.current_line;
                src = SRC_BIOS;
            end
            else if (req.link_value[7:4] == HARD_NIBBLE)
            begin
                irq = req.link_value[3:0];
                src = SRC_HARD;
            end
            else if (cfg.router_present && req.router_irq != '0)
            begin
                irq = req.router_irq;
                src = SRC_FOUND;
            end
            else if (cfg.router_present && req.assign_allowed && !req.is_display)
            begin
                irq = pick;
                src = SRC_NEW;
            end
        end
        // nothing granted: every field reads zero
        if (irq == '0)
        begin
            result = '0;
        end
        else
        begin
            result.granted_irq    = irq;
            result.source         = src;
            result.program_router = (src == SRC_NEW);
        end
    end

endmodule

@@ hw/rtl/pci_irq_penalty_allocator.sv @@
// Top level of the PCI IRQ routing allocator with penalty-based assignment.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------
//  request  | in_valid / in_ready  | in_data  (pia_pkg::in_t)
//  result   | out_valid / out_ready| out_data (pia_pkg::out_t)
//  config   | cfg_we               | cfg_index, cfg_data
//
// One transaction per cycle sustained while out_ready stays high; a request
// loads the input register at acceptance, and its result loads the result
// register when the input register advances and raises out_valid. The whole
// decision, including the 16-way penalty compare tree, sits between those two
// registers, and the usage counters update as the result is registered, so the
// next request already sees the new counts.
// Reset clears the counters and loads the register defaults at once.
// A stalled result holds in the output register; the input register still
// advances into it in the cycle the result is taken.
`timescale 1ns / 1ps

module pci_irq_penalty_allocator #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  pia_pkg::in_t   in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output pia_pkg::out_t  out_data,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [15:0]    cfg_data
);
    import pia_pkg::*;

    localparam int PEN_W = ((COUNT_WIDTH > BASE_W) ? COUNT_WIDTH : BASE_W) + 1;

    cfg_t                 cfg_reg;
    in_t                  req_reg;
    logic                 req_valid_reg;
    out_t                 res_reg;
    logic                 res_valid_reg;

    logic                 advance;
    logic [15:0]          pick_mask;
    logic [IRQ_IDX_W-1:0] pick;
    out_t                 result;
    logic [PEN_W-1:0]     penalty [NUM_IRQS];

    // advance the input register whenever the result slot is free or draining
    assign advance   = req_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready  = !req_valid_reg || advance;
    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.table_present    <= 1'b0;
            cfg_reg.router_present   <= 1'b0;
            cfg_reg.allowed_irq_mask <= ALLOWED_MASK_RESET;
            cfg_reg.exclusive_irqs   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TABLE_PRESENT:    cfg_reg.table_present    <= cfg_data[0];
                CFG_ROUTER_PRESENT:   cfg_reg.router_present   <= cfg_data[0];
                CFG_ALLOWED_IRQ_MASK: cfg_reg.allowed_irq_mask <= cfg_data;
                CFG_EXCLUSIVE_IRQS:   cfg_reg.exclusive_irqs   <= cfg_data;
                default:              cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // valid flags of the two stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                req_valid_reg <= in_valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= in_data;
        end
        if (advance)
        begin
            res_reg <= result;
        end
    end

    pia_usage_bank #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .PEN_W       (PEN_W)
    ) u_usage (
        .clk            (clk),
        .rst_n          (rst_n),
        .exclusive_irqs (cfg_reg.exclusive_irqs),
        .inc_en         (advance && result.granted_irq != '0),
        .inc_idx        (result.granted_irq),
        .penalty        (penalty)
    );

    pia_argmin #(
        .PEN_W (PEN_W)
    ) u_argmin (
        .penalty (penalty),
        .mask    (pick_mask),
        .pick    (pick)
    );

    pia_route u_route (
        .cfg       (cfg_reg),
        .req       (req_reg),
        .pick      (pick),
        .pick_mask (pick_mask),
        .result    (result)
    );

    // a result with no source grants nothing and never programs the router
    a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.source == SRC_NONE) |->
            (res_reg.granted_irq == '0 && !res_reg.program_router))
        else $error("source none with a nonzero grant");

    // router programming only goes with a new assignment
    a_prog_new: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.program_router) |-> (res_reg.source == SRC_NEW))
        else $error("program_router without a new assignment");

    // a granted IRQ always names a source
    a_grant_src: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.granted_irq != '0) |-> (res_reg.source != SRC_NONE))
        else $error("grant without a source");

    // a full pipe with a stalled result takes no new transaction
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid_reg && res_valid_reg && !out_ready) |-> !in_ready)
        else $error("request accepted into a full pipe");

endmodule
